// ----- hdl/pcpd_pkg.sv -----
// Shared types, sizes and helpers of the preamble correlation peak detector.
// Used by pcpd_cell, preamble_correlation_peak_detector_top and the testbench; no dependencies.
package pcpd_pkg;

	localparam int TAPS      = 64;
	localparam int MAX_FRAME = 4096;

	localparam int SMP_W   = 16;
	localparam int IDX_W   = 6;
	localparam int INDEX_W = 12;
	localparam int SUM_W   = 38;
	localparam int PROD_W  = 2 * SMP_W;
	localparam int ACC_W   = (PROD_W + $clog2(TAPS) > SUM_W) ? PROD_W + $clog2(TAPS) : SUM_W;

	localparam int COUNT_CAP = MAX_FRAME + TAPS;
	localparam int CNT_W     = $clog2(COUNT_CAP + 1);
	localparam int WAIT_W    = $clog2(TAPS + 2);

	localparam logic [0:0] ACT_COEFF  = 1'b0;
	localparam logic [0:0] ACT_SAMPLE = 1'b1;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic shift;
		logic load;
		smp_t coeff;
	} cell_ctl_t;

	// clamp the chain sum to the signed 38-bit result range
	function automatic sum_t sat_sum(input acc_t a);
		acc_t hi;
		acc_t lo;
		hi = {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
		lo = ~hi;
		if (a > hi) begin
			return SUM_W'(hi);
		end else if (a < lo) begin
			return SUM_W'(lo);
		end
		return SUM_W'(a);
	endfunction

endpackage

// ----- hdl/pcpd_cell.sv -----
// One tap of the correlator chain: coefficient, sample, product and partial sum.
// Depends on pcpd_pkg.
module pcpd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  pcpd_pkg::cell_ctl_t ctl,
	input  pcpd_pkg::smp_t      sample_in,
	output pcpd_pkg::smp_t      sample_out,
	input  pcpd_pkg::acc_t      psum_in,
	output pcpd_pkg::acc_t      psum_out
);

	pcpd_pkg::smp_t                             coeff_q;
	pcpd_pkg::smp_t                             sample_q;
	logic signed [pcpd_pkg::PROD_W-1:0]         prod_q;
	pcpd_pkg::acc_t                             psum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (ctl.load) begin
			coeff_q <= ctl.coeff;
		end
	end

	// samples move one cell toward the head on every sample transaction
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= sample_in;
		end
		prod_q <= coeff_q * sample_q;
		psum_q <= psum_in + pcpd_pkg::ACC_W'(prod_q);
	end

	assign sample_out = sample_q;
	assign psum_out   = psum_q;

endmodule

// ----- hdl/preamble_correlation_peak_detector_top.sv -----
// Preamble correlation peak detector: top level with cell chain and control.
// Depends on pcpd_pkg and pcpd_cell.
//
// Input channel s_axis: tuser selects the transaction kind (0 loads one
// coefficient at tdata[5:0] with value tdata[21:6], 1 delivers one received
// sample in tdata[21:6]); tlast marks the final sample of a frame.
// Output channel m_axis: one result per sample that completes a window or
// ends a frame; tlast marks the frame's final result, tuser carries the
// corr_valid and peak_found flags.
// Coefficient loads and samples that complete no window are taken one per
// cycle while the block is in ST_IDLE. A sample that completes a window
// waits in ST_CALC while the partial sum walks the chain of TAPS cells one
// cell per cycle, then passes ST_EMIT to the result register. A last sample
// without a window goes straight to ST_EMIT and from there to the result
// register.
// Reset clears the coefficients, the frame count and the running peak.
// When m_axis stalls, the result register holds; a further result waits in
// the block and s_axis_tready stays low until it moves to the register.
module preamble_correlation_peak_detector_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,  // coeff_index[5:0], value[21:6], zero pad
	input  logic         s_axis_tuser,  // action
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,  // corr_value[37:0], window_index[49:38],
	                                    // peak_value[87:50], peak_index[99:88], zero pad
	output logic [1:0]   m_axis_tuser,  // corr_valid[0], peak_found[1]
	output logic         m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam int TAPS    = pcpd_pkg::TAPS;
	localparam int CNT_W   = pcpd_pkg::CNT_W;
	localparam int INDEX_W = pcpd_pkg::INDEX_W;

	logic [1:0]                  state_q;
	logic [pcpd_pkg::WAIT_W-1:0] wait_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	logic                        last_q;
	logic [INDEX_W-1:0]          win_q;
	pcpd_pkg::sum_t              best_q;
	logic [INDEX_W-1:0]          best_idx_q;
	logic                        have_q;

	logic                        out_valid_q;
	pcpd_pkg::sum_t              out_corr_q;
	logic [INDEX_W-1:0]          out_win_q;
	pcpd_pkg::sum_t              out_peak_q;
	logic [INDEX_W-1:0]          out_pidx_q;
	logic                        out_cv_q;
	logic                        out_pf_q;
	logic                        out_last_q;

	logic                        s_fire;
	logic                        is_sample;
	logic [pcpd_pkg::IDX_W-1:0]  in_idx;
	pcpd_pkg::smp_t              in_value;
	logic [CNT_W-1:0]            cnt_nxt;
	logic                        win_done;
	logic [31:0]                 w32;
	logic [31:0]                 win32;
	logic                        out_free;
	pcpd_pkg::sum_t              sum_sat;
	logic                        take;
	pcpd_pkg::sum_t              peak_nxt;
	logic [INDEX_W-1:0]          pidx_nxt;

	pcpd_pkg::cell_ctl_t         ctl[TAPS];
	pcpd_pkg::smp_t              smp[TAPS+1];
	pcpd_pkg::acc_t              psum[TAPS+1];

	assign in_idx    = s_axis_tdata[5:0];
	assign in_value  = s_axis_tdata[21:6];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign is_sample = (s_axis_tuser == pcpd_pkg::ACT_SAMPLE);

	// saturating frame count and window start of this sample
	always_comb begin
		cnt_nxt  = (32'(cnt_q) < 32'(pcpd_pkg::COUNT_CAP)) ? cnt_q + CNT_W'(1) : cnt_q;
		win_done = (32'(cnt_nxt) >= 32'(TAPS));
		w32      = 32'(cnt_nxt) - 32'(TAPS);
		win32    = (w32 > 32'(pcpd_pkg::MAX_FRAME - 1)) ? 32'(pcpd_pkg::MAX_FRAME - 1) : w32;
	end

	// cell chain: samples enter at the tail, partial sums run from cell 0
	assign smp[TAPS] = in_value;
	assign psum[0]   = '0;

	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		always_comb begin
			ctl[j].shift = s_fire && is_sample;
			ctl[j].load  = s_fire && !is_sample && (32'(in_idx) == j);
			ctl[j].coeff = in_value;
		end

		pcpd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[j]),
			.sample_in  (smp[j+1]),
			.sample_out (smp[j]),
			.psum_in    (psum[j]),
			.psum_out   (psum[j+1])
		);
	end

	// peak update, only evaluated for the result leaving ST_EMIT
	always_comb begin
		out_free = !out_valid_q || m_axis_tready;
		sum_sat  = pcpd_pkg::sat_sum(psum[TAPS]);
		take     = done_q && (!have_q || sum_sat > best_q);
		peak_nxt = take ? sum_sat : best_q;
		pidx_nxt = take ? win_q : best_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			last_q      <= 1'b0;
			best_q      <= '0;
			best_idx_q  <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire && is_sample) begin
						cnt_q  <= cnt_nxt;
						done_q <= win_done;
						last_q <= s_axis_tlast;
						if (win_done) begin
							wait_q  <= pcpd_pkg::WAIT_W'(TAPS + 1);
							state_q <= ST_CALC;
						end else if (s_axis_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CALC: begin
					// hold until the sum has left the last cell
					if (wait_q == pcpd_pkg::WAIT_W'(1)) begin
						state_q <= ST_EMIT;
					end
					wait_q <= wait_q - pcpd_pkg::WAIT_W'(1);
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						if (last_q) begin
							cnt_q      <= '0;
							best_q     <= '0;
							best_idx_q <= '0;
							have_q     <= 1'b0;
						end else begin
							best_q     <= peak_nxt;
							best_idx_q <= pidx_nxt;
							have_q     <= have_q || done_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && is_sample) begin
			win_q <= win32[INDEX_W-1:0];
		end
		if (state_q == ST_EMIT && out_free) begin
			out_cv_q   <= done_q;
			out_corr_q <= done_q ? sum_sat : '0;
			out_win_q  <= done_q ? win_q : '0;
			out_pf_q   <= have_q || done_q;
			out_peak_q <= (have_q || done_q) ? peak_nxt : '0;
			out_pidx_q <= (have_q || done_q) ? pidx_nxt : '0;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_pidx_q, out_peak_q, out_win_q, out_corr_q};
	assign m_axis_tuser  = {out_pf_q, out_cv_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- hdl/pcpd_checker.sv -----
// Port-level checks of the preamble correlation peak detector, bound to the top.
// Depends on preamble_correlation_peak_detector_top port names only.
module pcpd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a stalled transaction keeps valid high
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a result without a window only closes a frame
	a_nowin_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[49:0] == 50'd0)
		else $error("windowless result not at end of frame");

	// a completed window always leaves a peak
	a_win_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("window without peak");

	// no peak means zero peak fields
	a_nopeak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[99:50] == 50'd0)
		else $error("peak fields set without peak");

endmodule

bind preamble_correlation_peak_detector_top pcpd_checker u_pcpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- dv/testbench.sv -----
// Testbench of the preamble correlation peak detector: streams coefficient loads and frames
// of samples, predicts each result in a scoreboard and checks m_axis against it.
// Depends on pcpd_pkg and preamble_correlation_peak_detector_top.
module testbench;

	localparam int TAPS        = pcpd_pkg::TAPS;
	localparam int MAX_FRAME   = pcpd_pkg::MAX_FRAME;
	localparam int COUNT_CAP   = pcpd_pkg::COUNT_CAP;
	localparam int SUM_W       = pcpd_pkg::SUM_W;
	localparam int INDEX_W     = pcpd_pkg::INDEX_W;
	localparam int IDX_W       = pcpd_pkg::IDX_W;
	localparam logic [0:0] ACT_COEFF  = pcpd_pkg::ACT_COEFF;
	localparam logic [0:0] ACT_SAMPLE = pcpd_pkg::ACT_SAMPLE;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_PRINTS  = 100;

	typedef pcpd_pkg::smp_t smp_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_MAX,
		FILL_MIN,
		FILL_SMALL,
		FILL_CONST,
		FILL_ZERO,
		FILL_ALT
	} fill_mode_t;

	typedef struct packed {
		logic               corr_valid;
		logic [SUM_W-1:0]   corr_value;
		logic [INDEX_W-1:0] window_index;
		logic [SUM_W-1:0]   peak_value;
		logic [INDEX_W-1:0] peak_index;
		logic               peak_found;
		logic               frame_done;
	} corr_result_t;

	class peak_scoreboard;
		smp_t         coeff[TAPS];
		smp_t         recent[TAPS];
		int unsigned  frame_samples;
		longint       best_sum;
		int unsigned  best_window;
		bit           have_best;
		corr_result_t expected_q[$];
		int unsigned  mismatches;

		function new();
			foreach (coeff[i]) coeff[i] = '0;
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			foreach (recent[i]) recent[i] = '0;
			frame_samples = 0;
			best_sum = 0;
			best_window = 0;
			have_best = 0;
		endfunction

		// work out the result, if any, that one accepted transaction causes
		function void predict_item(input logic act, input logic [IDX_W-1:0] idx,
				input smp_t val, input logic lst);
			longint       acc;
			int unsigned  win;
			bit           done;
			corr_result_t r;
			if (act == ACT_COEFF) begin
				coeff[idx] = val;
				return;
			end
			for (int j = 0; j < TAPS - 1; j++) recent[j] = recent[j + 1];
			recent[TAPS - 1] = val;
			if (frame_samples < COUNT_CAP) frame_samples++;
			acc = 0;
			win = 0;
			done = 0;
			if (frame_samples >= TAPS) begin
				win = frame_samples - TAPS;
				if (win > MAX_FRAME - 1) win = MAX_FRAME - 1;
				for (int j = 0; j < TAPS; j++) acc += longint'(coeff[j]) * longint'(recent[j]);
				done = 1;
				// strictly greater only: the first window keeps a tie
				if (!have_best || acc > best_sum) begin
					best_sum = acc;
					best_window = win;
					have_best = 1;
				end
			end
			if (!done && !lst) return;
			r.corr_valid   = done;
			r.corr_value   = done ? SUM_W'(acc) : '0;
			r.window_index = done ? INDEX_W'(win) : '0;
			r.peak_value   = have_best ? SUM_W'(best_sum) : '0;
			r.peak_index   = have_best ? INDEX_W'(best_window) : '0;
			r.peak_found   = have_best;
			r.frame_done   = lst;
			expected_q.push_back(r);
			if (lst) clear_frame();
		endfunction

		task report(input string msg);
			if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(input string name, input logic [63:0] got,
				input logic [63:0] want);
			if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
		endtask

		task check_result(input logic [103:0] data, input logic [1:0] flags,
				input logic lst);
			corr_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing pending, data %h", data));
				return;
			end
			want = expected_q.pop_front();
			compare_field("corr_valid", 64'(flags[0]), 64'(want.corr_valid));
			compare_field("corr_value", 64'(data[37:0]), 64'(want.corr_value));
			compare_field("window_index", 64'(data[49:38]), 64'(want.window_index));
			compare_field("peak_value", 64'(data[87:50]), 64'(want.peak_value));
			compare_field("peak_index", 64'(data[99:88]), 64'(want.peak_index));
			compare_field("peak_found", 64'(flags[1]), 64'(want.peak_found));
			compare_field("frame_done", 64'(lst), 64'(want.frame_done));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata = '0;   // coeff_index[5:0], value[21:6], zero pad
	logic         s_axis_tuser = 1'b0; // action
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;        // corr_value, window_index, peak_value, peak_index, pad
	logic [1:0]   m_axis_tuser;        // corr_valid[0], peak_found[1]
	logic         m_axis_tlast;

	logic           rx_hold = 1'b0;
	int             send_idle_pct = 0;
	int             rx_stall_pct = 0;
	int unsigned    items_sent = 0;
	peak_scoreboard board;

	preamble_correlation_peak_detector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	// offer one transaction, idling first at random, and hold it until accepted
	task automatic offer_item(input logic act, input logic [IDX_W-1:0] idx, input smp_t val,
			input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {2'b00, val, idx};
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		board.predict_item(act, idx, val, lst);
		items_sent++;
	endtask

	function automatic smp_t pick_value(input fill_mode_t mode, input smp_t base, input int pos);
		case (mode)
			FILL_MAX:   return 16'sh7fff;
			FILL_MIN:   return 16'sh8000;
			FILL_SMALL: return smp_t'(int'($urandom_range(6)) - 3);
			FILL_CONST: return base;
			FILL_ZERO:  return '0;
			FILL_ALT:   return pos[0] ? 16'sh7fff : 16'sh8000;
			default:    return smp_t'($urandom);
		endcase
	endfunction

	function automatic fill_mode_t pick_mode();
		if ($urandom_range(1)) return FILL_RANDOM;
		return fill_mode_t'($urandom_range(FILL_ALT));
	endfunction

	task automatic load_coeffs(input fill_mode_t mode);
		smp_t base;
		base = smp_t'($urandom);
		for (int i = 0; i < TAPS; i++) begin
			offer_item(ACT_COEFF, IDX_W'(i), pick_value(mode, base, i), 1'($urandom_range(1)));
		end
	endtask

	task automatic stream_frame(input int len, input fill_mode_t mode);
		smp_t base;
		base = smp_t'($urandom);
		for (int i = 0; i < len; i++) begin
			// slip a coefficient load into the frame now and then
			if ($urandom_range(19) == 0) begin
				offer_item(ACT_COEFF, IDX_W'($urandom_range(63)), smp_t'($urandom),
					1'($urandom_range(1)));
			end
			offer_item(ACT_SAMPLE, IDX_W'($urandom_range(63)), pick_value(mode, base, i),
				i == len - 1);
		end
	endtask

	task automatic run_traffic(input int budget);
		int unsigned stop_at;
		int          r;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			r = $urandom_range(9);
			if (r < 2) begin
				load_coeffs(pick_mode());
			end else if (r < 6) begin
				repeat ($urandom_range(1, 6)) begin
					offer_item(ACT_COEFF, IDX_W'($urandom_range(63)), smp_t'($urandom),
						1'($urandom_range(1)));
				end
			end
			if ($urandom_range(9) < 2) begin
				stream_frame($urandom_range(1, TAPS - 1), pick_mode());
			end else begin
				stream_frame($urandom_range(TAPS, TAPS + 12), pick_mode());
			end
		end
	endtask

	// drop tvalid, then wait for every pending result
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.expected_q.size() != 0);
	endtask

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_item(ACT_SAMPLE, 6'h3f, 16'sh7fff, 1'b1);
		offer_item(ACT_COEFF, 6'h00, 16'sh7fff, 1'b1);
		offer_item(ACT_COEFF, 6'h3f, 16'sh8000, 1'b0);
		offer_item(ACT_COEFF, 6'h2a, 16'sh5555, 1'b1);
		offer_item(ACT_COEFF, 6'h15, 16'shaaaa, 1'b0);
		offer_item(ACT_SAMPLE, 6'h00, 16'sh8000, 1'b0);
		offer_item(ACT_SAMPLE, 6'h2a, 16'sh0000, 1'b0);
		offer_item(ACT_SAMPLE, 6'h15, 16'shffff, 1'b0);
		offer_item(ACT_SAMPLE, 6'h3f, 16'sh0001, 1'b1);
		offer_item(ACT_SAMPLE, 6'h00, 16'sh8000, 1'b1);
		offer_item(ACT_SAMPLE, 6'h2a, 16'sh7fff, 1'b0);
		offer_item(ACT_SAMPLE, 6'h15, 16'sh8000, 1'b1);
		offer_item(ACT_COEFF, 6'h00, 16'sh0000, 1'b0);
		offer_item(ACT_COEFF, 6'h3f, 16'sh0000, 1'b1);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					rx_stall_pct  = 0;
				end
				1: begin
					send_idle_pct = 88;
					rx_stall_pct  = 0;
				end
				2: begin
					send_idle_pct = 0;
					rx_stall_pct  = 88;
				end
				default: begin
					send_idle_pct = 23;
					rx_stall_pct  = 23;
				end
			endcase
			run_traffic(170);
			wait_drain();
		end

		// hold off the receiver while a frame with windows keeps coming
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		stream_frame(TAPS + 16, FILL_RANDOM);
		wait_drain();

		repeat (2 * (TAPS + 3)) @(posedge clk);
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pcpd_pkg.sv
hdl/pcpd_cell.sv
hdl/preamble_correlation_peak_detector_top.sv
hdl/pcpd_checker.sv
dv/testbench.sv
